// ----- src/iae_pkg.sv -----
// ----------------------------------------------------------------------------
// iae_pkg: shared types and constants for the indexed array engine
// Sizes, opcode and status codes, request/response payloads and the command
// broadcast along the row of storage cells.
// ----------------------------------------------------------------------------
package iae_pkg;

	localparam int DEPTH        = 64;
	localparam int ELEMENT_BITS = 32;
	localparam int IDX_BITS     = $clog2(DEPTH);
	localparam int CNT_BITS     = $clog2(DEPTH + 1);
	localparam int GROUP_SIZE   = 8;
	localparam int NUM_GROUPS   = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

	localparam logic [2:0] OP_PUSH   = 3'd0;
	localparam logic [2:0] OP_POP    = 3'd1;
	localparam logic [2:0] OP_GET    = 3'd2;
	localparam logic [2:0] OP_SET    = 3'd3;
	localparam logic [2:0] OP_INSERT = 3'd4;
	localparam logic [2:0] OP_REMOVE = 3'd5;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_BADIDX = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef logic [ELEMENT_BITS-1:0] entry_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [5:0]  position;
		logic [31:0] element_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] element_out;
		logic [6:0]  live_count;
	} rsp_t;

	// command seen by every cell in the same cycle
	typedef struct packed {
		logic                up;
		logic                down;
		logic                wr;
		logic                rd;
		logic [IDX_BITS-1:0] idx;
		logic [IDX_BITS-1:0] rd_idx;
		entry_t              value;
	} cell_cmd_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [CNT_BITS-1:0] count;
	} result_t;

endpackage

// ----- src/indexed_array_engine_top.sv -----
// ----------------------------------------------------------------------------
// indexed_array_engine_top: bounded ordered array with insert and remove
// A row of element cells under a shared command; push, pop, get, set,
// insert and remove, each answered with status, element and live count.
//
//   channel | direction | payload           | handshake
//   req     | in        | iae_pkg::req_t    | req_valid / req_ready
//   rsp     | out       | iae_pkg::rsp_t    | rsp_valid / rsp_ready
//
// one request per cycle while rsp_ready is high; the cell row moves the whole
// tail in the accept cycle, so the next request sees the updated contents
// the read value of a taken request passes through the grouped OR stage
// register and then the response register before the response leaves
// a stalled response holds one more request in the read stage, then
// req_ready drops until rsp_ready returns
// reset clears the fill count and both valid flags; element storage is not
// cleared and needs no sweep
// ----------------------------------------------------------------------------
module indexed_array_engine_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  iae_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output iae_pkg::rsp_t rsp
);

	logic               accept;
	iae_pkg::cell_cmd_t cmd;
	iae_pkg::result_t   res;
	iae_pkg::entry_t    cell_q  [iae_pkg::DEPTH];
	iae_pkg::entry_t    rd_data [iae_pkg::DEPTH];

	assign accept = req_valid && req_ready;

	iae_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.cmd    (cmd),
		.res    (res)
	);

	for (genvar i = 0; i < iae_pkg::DEPTH; i++) begin : g_cell
		iae_pkg::entry_t left_v;
		iae_pkg::entry_t right_v;

		// the row ends take zero from outside
		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_q[i-1];
		end
		if (i == iae_pkg::DEPTH - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_q[i+1];
		end

		iae_cell u_cell (
			.clk     (clk),
			.slot    (iae_pkg::IDX_BITS'(i)),
			.cmd     (cmd),
			.left    (left_v),
			.right   (right_v),
			.q       (cell_q[i]),
			.rd_data (rd_data[i])
		);
	end

	iae_gather u_gather (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.res       (res),
		.rd_data   (rd_data),
		.rsp_ready (rsp_ready),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ----- src/iae_cell.sv -----
// ----------------------------------------------------------------------------
// iae_cell: one storage slot of the element row
// Holds one element; on a command it keeps it, loads the new value, or takes
// the neighbour's value so the whole tail moves up or down together.
// ----------------------------------------------------------------------------
module iae_cell (
	input  logic                         clk,
	input  logic [iae_pkg::IDX_BITS-1:0] slot,
	input  iae_pkg::cell_cmd_t           cmd,
	input  iae_pkg::entry_t              left,
	input  iae_pkg::entry_t              right,
	output iae_pkg::entry_t              q,
	output iae_pkg::entry_t              rd_data
);

	iae_pkg::entry_t value_q;

	always_ff @(posedge clk) begin
		priority if (cmd.up && slot > cmd.idx) begin
			value_q <= left;
		end else if (cmd.down && slot >= cmd.idx) begin
			value_q <= right;
		end else if ((cmd.up || cmd.wr) && slot == cmd.idx) begin
			value_q <= cmd.value;
		end else begin
			value_q <= value_q;
		end
	end

	assign q = value_q;
	// old contents are read, before this cycle's update lands
	assign rd_data = (cmd.rd && slot == cmd.rd_idx) ? value_q : '0;

endmodule

// ----- src/iae_ctrl.sv -----
// ----------------------------------------------------------------------------
// iae_ctrl: command decode and fill count
// Checks each request against the fill count, sets the status and new count,
// and builds the shift/write/read command broadcast to the cell row.
// ----------------------------------------------------------------------------
module iae_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  iae_pkg::req_t      req,
	output iae_pkg::cell_cmd_t cmd,
	output iae_pkg::result_t   res
);

	logic [iae_pkg::CNT_BITS-1:0] count_q;
	logic [iae_pkg::CNT_BITS-1:0] pos_c;
	logic                         full;
	logic                         empty;
	logic                         up_c;
	logic                         down_c;
	logic                         wr_c;
	logic                         rd_c;

	always_comb begin
		pos_c = iae_pkg::CNT_BITS'(req.position);
		full = (count_q == iae_pkg::CNT_BITS'(iae_pkg::DEPTH));
		empty = (count_q == '0);
		up_c = 1'b0;
		down_c = 1'b0;
		wr_c = 1'b0;
		rd_c = 1'b0;
		cmd.idx = iae_pkg::IDX_BITS'(req.position);
		cmd.rd_idx = iae_pkg::IDX_BITS'(req.position);
		cmd.value = req.element_in[iae_pkg::ELEMENT_BITS-1:0];
		res.status = iae_pkg::ST_OK;
		res.count = count_q;
		unique case (req.opcode)
			iae_pkg::OP_PUSH: begin
				if (full) begin
					res.status = iae_pkg::ST_FULL;
				end else begin
					wr_c = 1'b1;
					cmd.idx = iae_pkg::IDX_BITS'(count_q);
					res.count = count_q + 1'b1;
				end
			end
			iae_pkg::OP_POP: begin
				if (empty) begin
					res.status = iae_pkg::ST_EMPTY;
				end else begin
					rd_c = 1'b1;
					cmd.rd_idx = iae_pkg::IDX_BITS'(count_q - 1'b1);
					res.count = count_q - 1'b1;
				end
			end
			iae_pkg::OP_GET: begin
				if (pos_c >= count_q) begin
					res.status = iae_pkg::ST_BADIDX;
				end else begin
					rd_c = 1'b1;
				end
			end
			iae_pkg::OP_SET: begin
				if (pos_c >= count_q) begin
					res.status = iae_pkg::ST_BADIDX;
				end else begin
					wr_c = 1'b1;
				end
			end
			iae_pkg::OP_INSERT: begin
				// index is checked before fullness
				if (pos_c > count_q) begin
					res.status = iae_pkg::ST_BADIDX;
				end else if (full) begin
					res.status = iae_pkg::ST_FULL;
				end else begin
					up_c = 1'b1;
					res.count = count_q + 1'b1;
				end
			end
			iae_pkg::OP_REMOVE: begin
				if (pos_c >= count_q) begin
					res.status = iae_pkg::ST_BADIDX;
				end else begin
					rd_c = 1'b1;
					down_c = 1'b1;
					res.count = count_q - 1'b1;
				end
			end
			default: begin
				res.status = iae_pkg::ST_BADIDX;
			end
		endcase
		cmd.up = up_c && accept;
		cmd.down = down_c && accept;
		cmd.wr = wr_c && accept;
		cmd.rd = rd_c && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= res.count;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= iae_pkg::CNT_BITS'(iae_pkg::DEPTH))
		else $error("fill count above capacity");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.opcode == iae_pkg::OP_PUSH && res.status == iae_pkg::ST_OK
		|=> count_q == iae_pkg::CNT_BITS'($past(count_q) + 1'b1))
		else $error("push did not grow the count");

	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.status != iae_pkg::ST_OK |=> count_q == $past(count_q))
		else $error("refused request changed the count");

	a_no_shift_refused: assert property (@(posedge clk) disable iff (!arst_n)
		res.status != iae_pkg::ST_OK |-> !(cmd.up || cmd.down || cmd.wr || cmd.rd))
		else $error("refused request reached the cell row");

endmodule

// ----- src/iae_gather.sv -----
// ----------------------------------------------------------------------------
// iae_gather: read collection and response stage
// ORs the cells' read outputs in groups into a stage register, then folds the
// groups into the response register that holds under back-pressure.
// ----------------------------------------------------------------------------
module iae_gather (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  iae_pkg::result_t res,
	input  iae_pkg::entry_t  rd_data [iae_pkg::DEPTH],
	input  logic             rsp_ready,
	output logic             req_ready,
	output logic             rsp_valid,
	output iae_pkg::rsp_t    rsp
);

	iae_pkg::entry_t              group_or [iae_pkg::NUM_GROUPS];
	iae_pkg::entry_t              group_s1 [iae_pkg::NUM_GROUPS];
	iae_pkg::entry_t              elem_or;
	logic [1:0]                   status_s1;
	logic [iae_pkg::CNT_BITS-1:0] count_s1;
	logic                         valid_s1;
	logic                         rsp_valid_q;
	iae_pkg::rsp_t                rsp_q;
	logic                         move;

	// at most one cell drives a non-zero read value
	always_comb begin
		for (int g = 0; g < iae_pkg::NUM_GROUPS; g++) begin
			group_or[g] = '0;
			for (int k = 0; k < iae_pkg::GROUP_SIZE; k++) begin
				if (g * iae_pkg::GROUP_SIZE + k < iae_pkg::DEPTH) begin
					group_or[g] = group_or[g] | rd_data[g * iae_pkg::GROUP_SIZE + k];
				end
			end
		end
	end

	always_comb begin
		elem_or = '0;
		for (int g = 0; g < iae_pkg::NUM_GROUPS; g++) begin
			elem_or = elem_or | group_s1[g];
		end
	end

	assign move = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			group_s1 <= group_or;
			status_s1 <= res.status;
			count_s1 <= res.count;
		end
		if (move) begin
			rsp_q.status <= status_s1;
			rsp_q.element_out <= 32'(elem_or);
			rsp_q.live_count <= 7'(count_s1);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
